// ===== design/rqd_pkg.sv =====
// rqd_pkg: shared types and codes for the ready queue dispatcher
// entry, beat and cell-control types; no dependencies
`timescale 1ns / 1ps

package rqd_pkg;

  localparam int RQD_DEPTH = 16;

  // byte address of the algorithm register
  localparam logic [1:0] ADDR_ALGORITHM = 2'd0;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_REMOVE   = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;

  typedef enum logic [3:0] {
    ST_INSERTED   = 4'd0,
    ST_REMOVED    = 4'd1,
    ST_DISPATCHED = 4'd2,
    ST_KEEP       = 4'd3,
    ST_NOTHING    = 4'd4,
    ST_DUP        = 4'd5,
    ST_FULL       = 4'd6,
    ST_NOTFOUND   = 4'd7,
    ST_EMPTY      = 4'd8
  } rqd_status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] process_id;
    logic [15:0] remaining_time;
    logic [15:0] arrival_time;
    logic        cpu_busy;
  } rqd_in_t;

  typedef struct packed {
    rqd_status_t status;
    logic [15:0] chosen_id;
    logic [4:0]  occupancy;
  } rqd_out_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] remaining;
    logic [15:0] arrival;
  } rqd_entry_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic rotate;
    logic shift;
    logic load;
  } rqd_cell_op_t;

endpackage

// ===== design/rqd_cell.sv =====
// rqd_cell: one slot of the ready table chain
// depends on rqd_pkg; takes data from its upper neighbor
`timescale 1ns / 1ps

module rqd_cell #(
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic [IDX_W-1:0]      cell_idx,
  input  rqd_pkg::rqd_cell_op_t op,
  input  logic [IDX_W-1:0]      pos,
  input  rqd_pkg::rqd_entry_t   new_entry,
  input  rqd_pkg::rqd_entry_t   nbr,
  output rqd_pkg::rqd_entry_t   entry
);
  import rqd_pkg::*;

  rqd_entry_t entry_r;
  rqd_entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (op.rotate) begin
      entry_nxt = nbr;
    end else if (op.shift && (cell_idx >= pos)) begin
      // close the gap left by the removed slot
      entry_nxt = nbr;
    end else if (op.load && (cell_idx == pos)) begin
      entry_nxt = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ===== design/rqd_ctrl.sv =====
// rqd_ctrl: command sequencer, head-of-chain scan and result register
// depends on rqd_pkg; drives the cell chain through rqd_cell_op_t
`timescale 1ns / 1ps

module rqd_ctrl #(
  parameter int DEPTH = rqd_pkg::RQD_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rqd_pkg::rqd_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rqd_pkg::rqd_out_t               out_data,
  input  logic                            algorithm,
  input  rqd_pkg::rqd_entry_t             head,
  output rqd_pkg::rqd_cell_op_t           cell_op,
  output logic [$clog2(DEPTH)-1:0]        cell_pos,
  output rqd_pkg::rqd_entry_t             cell_entry
);
  import rqd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESOLVE, S_UPDATE} state_t;

  state_t         state_r,     state_nxt;
  logic [IDX_W-1:0] step_r,    step_nxt;
  logic [IDX_W-1:0] pos_r,     pos_nxt;
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [1:0]     cmd_r,       cmd_nxt;
  rqd_entry_t     item_r,      item_nxt;
  logic           found_r,     found_nxt;
  logic [15:0]    chosen_r,    chosen_nxt;
  logic [15:0]    best_rem_r,  best_rem_nxt;
  logic [15:0]    best_arr_r,  best_arr_nxt;
  rqd_status_t    status_r,    status_nxt;
  logic           out_valid_r, out_valid_nxt;
  rqd_out_t       out_data_r,  out_data_nxt;

  logic out_free;
  logic in_range;
  logic better;
  logic is_full;
  logic is_empty;

  assign out_free = !out_valid_r || out_ready;
  assign in_range = (CNT_W + 1)'(step_r) < (CNT_W + 1)'(count_r);
  assign better   = (head.remaining < best_rem_r) ||
                    ((head.remaining == best_rem_r) && (head.arrival < best_arr_r));
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    cmd_nxt       = cmd_r;
    item_nxt      = item_r;
    found_nxt     = found_r;
    chosen_nxt    = chosen_r;
    best_rem_nxt  = best_rem_r;
    best_arr_nxt  = best_arr_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cell_op       = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data.command;
          item_nxt.id        = in_data.process_id;
          item_nxt.remaining = in_data.remaining_time;
          item_nxt.arrival   = in_data.arrival_time;
          found_nxt      = 1'b0;
          chosen_nxt     = '0;
          step_nxt       = '0;
          pos_nxt        = '0;
          state_nxt      = S_UPDATE;
          unique case (in_data.command)
            CMD_INSERT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_REMOVE: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            CMD_DISPATCH: begin
              if (in_data.cpu_busy) begin
                status_nxt = ST_KEEP;
              end else if (is_empty) begin
                status_nxt = ST_NOTHING;
              end else if (!algorithm) begin
                // fcfs takes the head without a scan
                status_nxt = ST_DISPATCHED;
                chosen_nxt = head.id;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_NOTHING;
            end
          endcase
        end
      end

      S_SCAN: begin
        // chain rotates one slot a cycle; head holds original slot step_r
        cell_op.rotate = 1'b1;
        step_nxt = step_r + IDX_W'(1);
        case (cmd_r)
          CMD_INSERT: begin
            if (in_range && (head.id == item_r.id)) begin
              found_nxt = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (in_range && (head.id == item_r.id) && !found_r) begin
              found_nxt  = 1'b1;
              pos_nxt    = step_r;
              chosen_nxt = head.id;
            end
          end
          default: begin
            if ((step_r == '0) || (in_range && better)) begin
              best_rem_nxt = head.remaining;
              best_arr_nxt = head.arrival;
              pos_nxt      = step_r;
              chosen_nxt   = head.id;
            end
          end
        endcase
        if (step_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = S_RESOLVE;
        end
      end

      S_RESOLVE: begin
        case (cmd_r)
          CMD_INSERT: begin
            status_nxt = found_r ? ST_DUP : ST_INSERTED;
            pos_nxt    = count_r[IDX_W-1:0];
          end
          CMD_REMOVE: begin
            status_nxt = found_r ? ST_REMOVED : ST_NOTFOUND;
          end
          default: begin
            status_nxt = ST_DISPATCHED;
          end
        endcase
        state_nxt = S_UPDATE;
      end

      S_UPDATE: begin
        if (out_free) begin
          case (status_r) inside
            ST_INSERTED: begin
              cell_op.load = 1'b1;
              count_nxt    = count_r + CNT_W'(1);
            end
            ST_REMOVED, ST_DISPATCHED: begin
              cell_op.shift = 1'b1;
              count_nxt     = count_r - CNT_W'(1);
            end
            default: begin
            end
          endcase
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.chosen_id = chosen_r;
          out_data_nxt.occupancy = 5'(count_nxt);
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r     <= step_nxt;
    pos_r      <= pos_nxt;
    cmd_r      <= cmd_nxt;
    item_r     <= item_nxt;
    found_r    <= found_nxt;
    chosen_r   <= chosen_nxt;
    best_rem_r <= best_rem_nxt;
    best_arr_r <= best_arr_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cell_pos   = pos_r;
  assign cell_entry = item_r;

endmodule

// ===== design/ready_queue_dispatcher_top.sv =====
// ready queue dispatcher: ordered ready table with fcfs / sjf dispatch
// rejected, busy and fcfs-dispatch beats go idle to update; others go through scan and resolve
// one beat at a time: in_ready is high only in idle, and a scan rotates the cell chain once round
// reset: synchronous active-low rst_n empties the table and sets algorithm to fcfs
// table contents are not cleared; slots beyond the entry count are never looked at
// depends on rqd_pkg, rqd_cell, rqd_ctrl
`timescale 1ns / 1ps

module ready_queue_dispatcher_top #(
  parameter int DEPTH = rqd_pkg::RQD_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  // item channel
  input  logic              in_valid,
  output logic              in_ready,
  input  rqd_pkg::rqd_in_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output rqd_pkg::rqd_out_t out_data,
  // register port, single register at byte address 0
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import rqd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  // algorithm register: 0 fcfs, 1 shortest remaining time first
  logic algorithm_r;
  logic algorithm_nxt;

  // the algorithm register is the only one on the port
  assign pready = 1'b1;
  assign prdata = {31'b0, algorithm_r};

  always_comb begin
    algorithm_nxt = algorithm_r;
    if (psel && penable && pwrite && (paddr == ADDR_ALGORITHM)) begin
      algorithm_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      algorithm_r <= 1'b0;
    end else begin
      algorithm_r <= algorithm_nxt;
    end
  end

  // cell chain: cell i takes from cell i+1, the top cell wraps to cell 0,
  // so a full rotation walks every slot past the head and back in place
  rqd_entry_t   cells [DEPTH];
  rqd_cell_op_t cell_op;
  logic [IDX_W-1:0] cell_pos;
  rqd_entry_t   cell_entry;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rqd_cell #(
      .IDX_W(IDX_W)
    ) u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .op       (cell_op),
      .pos      (cell_pos),
      .new_entry(cell_entry),
      .nbr      (cells[(i + 1) % DEPTH]),
      .entry    (cells[i])
    );
  end

  // sequencer: looks at the head cell while the chain rotates,
  // then issues at most one load or shift and registers the result beat
  rqd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .algorithm (algorithm_r),
    .head      (cells[0]),
    .cell_op   (cell_op),
    .cell_pos  (cell_pos),
    .cell_entry(cell_entry)
  );

endmodule

// ===== verif/ready_queue_dispatcher_top_tb.sv =====
// self-checking bench for ready_queue_dispatcher_top: a directed table, then random phases
// in fcfs and sjf mode; results checked against typed rows or an in-bench ready table model
// depends on rqd_pkg and ready_queue_dispatcher_top
`timescale 1ns / 1ps

module ready_queue_dispatcher_top_tb;
  import rqd_pkg::*;

  localparam int DEPTH = RQD_DEPTH;
  localparam logic [1:0] CMD_NOP = 2'd3;          // no-op command code
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 4;
  localparam int PHASE_BEATS = 150;

  // one row of the directed table: either a register write or an input beat
  typedef struct {
    bit          is_cfg;
    logic [31:0] cfg_word;
    rqd_in_t     item;
    bit          typed;    // result written out by hand in the row
    rqd_out_t    result;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  rqd_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  rqd_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the ready table and the mode register
  logic [15:0] tbl_id [DEPTH];
  logic [15:0] tbl_rem [DEPTH];
  logic [15:0] tbl_arr [DEPTH];
  int          tbl_count;
  bit          sjf_mode;

  rqd_out_t    awaited_results [$];
  stim_row_t   stim_rows [$];
  int          mismatch_count;
  int          cycle_count;
  int          insert_pct;
  bit          calm;       // no idling on either side
  bit          hold_req;   // ask the result side for a long hold-off

  ready_queue_dispatcher_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // ready table model
  // ---------------------------------------------------------------------------

  // position of a live entry with this id, or -1
  function automatic int find_slot(input logic [15:0] pid);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == pid) return i;
    end
    return -1;
  endfunction

  // take the entry at pos out and close the gap so the order is kept
  function automatic logic [15:0] take_slot(input int pos);
    logic [15:0] pid;
    pid = tbl_id[pos];
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_id[i]  = tbl_id[i + 1];
      tbl_rem[i] = tbl_rem[i + 1];
      tbl_arr[i] = tbl_arr[i + 1];
    end
    tbl_count--;
    return pid;
  endfunction

  // apply one accepted beat to the table and return the result it must produce
  function automatic rqd_out_t ready_table_step(input rqd_in_t item);
    rqd_out_t res;
    int       pos;
    int       best;
    res.status    = ST_NOTHING;
    res.chosen_id = '0;
    case (item.command)
      CMD_INSERT: begin
        // full is checked ahead of duplicate
        if (tbl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else if (find_slot(item.process_id) >= 0) begin
          res.status = ST_DUP;
        end else begin
          tbl_id[tbl_count]  = item.process_id;
          tbl_rem[tbl_count] = item.remaining_time;
          tbl_arr[tbl_count] = item.arrival_time;
          tbl_count++;
          res.status = ST_INSERTED;
        end
      end
      CMD_REMOVE: begin
        if (tbl_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          pos = find_slot(item.process_id);
          if (pos < 0) begin
            res.status = ST_NOTFOUND;
          end else begin
            res.chosen_id = take_slot(pos);
            res.status    = ST_REMOVED;
          end
        end
      end
      CMD_DISPATCH: begin
        // a busy cpu keeps running, even with an empty table
        if (item.cpu_busy) begin
          res.status = ST_KEEP;
        end else if (tbl_count == 0) begin
          res.status = ST_NOTHING;
        end else begin
          best = 0;
          if (sjf_mode) begin
            // least remaining time, then earlier arrival, then earlier slot
            for (int i = 1; i < tbl_count; i++) begin
              if (tbl_rem[i] < tbl_rem[best] ||
                  (tbl_rem[i] == tbl_rem[best] && tbl_arr[i] < tbl_arr[best])) begin
                best = i;
              end
            end
          end
          res.chosen_id = take_slot(best);
          res.status    = ST_DISPATCHED;
        end
      end
      default: ;  // no-op command
    endcase
    res.occupancy = 5'(tbl_count);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic stim_row_t item_row(input logic [1:0] cmd, input logic [15:0] pid,
                                         input logic [15:0] rem, input logic [15:0] arr,
                                         input logic busy, input bit typed,
                                         input rqd_status_t st, input logic [15:0] chosen,
                                         input logic [4:0] occ);
    stim_row_t row;
    row.is_cfg                = 1'b0;
    row.cfg_word              = '0;
    row.item.command          = cmd;
    row.item.process_id       = pid;
    row.item.remaining_time   = rem;
    row.item.arrival_time     = arr;
    row.item.cpu_busy         = busy;
    row.typed                 = typed;
    row.result.status         = st;
    row.result.chosen_id      = chosen;
    row.result.occupancy      = occ;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [31:0] word);
    stim_row_t row;
    row        = item_row(CMD_NOP, '0, '0, '0, 1'b0, 1'b0, ST_NOTHING, '0, '0);
    row.is_cfg = 1'b1;
    row.cfg_word = word;
    return row;
  endfunction

  // a small id pool makes duplicates and remove hits common
  function automatic logic [15:0] random_id();
    int v;
    if ($urandom_range(99) < 75) begin
      v = $urandom_range(0, 23);
      return (v == 23) ? 16'hFFFF : 16'(v);
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly tiny values so sjf ties on time and arrival show up often
  function automatic logic [15:0] random_time();
    if ($urandom_range(99) < 60) return 16'($urandom_range(0, 7));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic rqd_in_t random_item();
    rqd_in_t it;
    int      r;
    it.process_id     = random_id();
    it.remaining_time = random_time();
    it.arrival_time   = random_time();
    it.cpu_busy       = ($urandom_range(99) < 25);
    r = $urandom_range(99);
    if (r < insert_pct) begin
      it.command = CMD_INSERT;
    end else if (r < insert_pct + (95 - insert_pct) / 2) begin
      it.command = CMD_REMOVE;
      // most removes name an id that is in the table
      if (tbl_count > 0 && $urandom_range(9) < 7) begin
        it.process_id = tbl_id[$urandom_range(0, tbl_count - 1)];
      end
    end else if (r < 95) begin
      it.command = CMD_DISPATCH;
    end else begin
      it.command = CMD_NOP;
    end
    return it;
  endfunction

  // offer one beat on the input channel; predict its result at the accepting edge
  task automatic offer_item(input rqd_in_t item, input bit typed, input rqd_out_t typed_res);
    rqd_out_t predicted;
    if (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid && in_ready));
    predicted = ready_table_step(item);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  // stop offering until every expected result beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // apb write of the algorithm register, only with the block idle
  task automatic write_algorithm(input logic [31:0] word);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ALGORITHM;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sjf_mode = word[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, the long hold-off, and the checker
  // ---------------------------------------------------------------------------
  initial begin : result_side
    rqd_out_t want;
    int       hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: status %0d id %h occupancy %0d",
                   $time, out_data.status, out_data.chosen_id, out_data.occupancy);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_data.status);
            mismatch_count++;
          end
          if (out_data.chosen_id !== want.chosen_id) begin
            $display("%0t: chosen_id expected %h actual %h", $time, want.chosen_id,
                     out_data.chosen_id);
            mismatch_count++;
          end
          if (out_data.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                     out_data.occupancy);
            mismatch_count++;
          end
        end
      end
      // long hold-off: counted here, the input side keeps offering meanwhile
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst_n && (calm || $urandom_range(99) >= 9);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: cycle limit reached with %0d results outstanding", $time,
                 awaited_results.size());
        $display("FAIL ready_queue_dispatcher_top");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : input_side
    logic [31:0] cfg_word;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tbl_count      = 0;
    sjf_mode       = 1'b0;
    mismatch_count = 0;
    insert_pct     = 45;
    calm           = 1'b0;
    hold_req       = 1'b0;

    // directed table, fcfs first
    // fcfs with every upper bit of the data word set
    stim_rows.push_back(cfg_row(32'hFFFF_FFFE));
    // empty table: idle dispatch, busy dispatch, remove, no-op with all-ones fields
    stim_rows.push_back(item_row(CMD_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_NOTHING, 16'h0000, 5'd0));
    stim_rows.push_back(item_row(CMD_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                                 1'b1, ST_KEEP, 16'h0000, 5'd0));
    stim_rows.push_back(item_row(CMD_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_EMPTY, 16'h0000, 5'd0));
    stim_rows.push_back(item_row(CMD_NOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                 1'b1, ST_NOTHING, 16'h0000, 5'd0));
    // fill the table; field extremes, and four entries with zero time for sjf ties
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd1));
    stim_rows.push_back(item_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd2));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd3));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h8000, 16'h8000, 16'h0001, 1'b1,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd4));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0101, 16'h0040, 16'h0010, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd5));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0102, 16'h0000, 16'h8000, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd6));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0103, 16'h0040, 16'h0010, 1'b1,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd7));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0104, 16'h5555, 16'hAAAA, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd8));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0105, 16'hAAAA, 16'h5555, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd9));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0106, 16'h0000, 16'h8000, 1'b1,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd10));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0107, 16'h0001, 16'h0000, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd11));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0108, 16'h0002, 16'h0003, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd12));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h0109, 16'h0040, 16'h000F, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd13));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h010A, 16'h1234, 16'h4321, 1'b1,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd14));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h010B, 16'hFFFE, 16'h0000, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd15));
    stim_rows.push_back(item_row(CMD_INSERT, 16'h010C, 16'h0003, 16'h0003, 1'b0,
                                 1'b1, ST_INSERTED, 16'h0000, 5'd16));
    // full table: a new id, then an id that is present (full wins over duplicate)
    stim_rows.push_back(item_row(CMD_INSERT, 16'h4242, 16'h0001, 16'h0001, 1'b0,
                                 1'b1, ST_FULL, 16'h0000, 5'd16));
    stim_rows.push_back(item_row(CMD_INSERT, 16'hFFFF, 16'h0001, 16'h0001, 1'b0,
                                 1'b1, ST_FULL, 16'h0000, 5'd16));
    // fcfs dispatch takes the head
    stim_rows.push_back(item_row(CMD_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_DISPATCHED, 16'h0000, 5'd15));
    // duplicate with room left, and an absent id
    stim_rows.push_back(item_row(CMD_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_DUP, 16'h0000, 5'd15));
    stim_rows.push_back(item_row(CMD_REMOVE, 16'h4242, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_NOTFOUND, 16'h0000, 5'd15));
    // sjf: zero-time ties, decided by arrival and then by slot order
    stim_rows.push_back(cfg_row(32'h0000_0001));
    stim_rows.push_back(item_row(CMD_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 1'b0, ST_NOTHING, 16'h0000, 5'd0));
    stim_rows.push_back(item_row(CMD_DISPATCH, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                 1'b0, ST_NOTHING, 16'h0000, 5'd0));
    // remove from the middle keeps the rest in order
    stim_rows.push_back(item_row(CMD_REMOVE, 16'h0103, 16'h0000, 16'h0000, 1'b0,
                                 1'b1, ST_REMOVED, 16'h0103, 5'd12));

    // reset once
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) write_algorithm(stim_rows[i].cfg_word);
      else offer_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].result);
    end

    // random phases alternating fcfs and sjf, random upper bits in the data word
    for (int p = 0; p < PHASES; p++) begin
      cfg_word    = $urandom;
      cfg_word[0] = p[0];
      write_algorithm(cfg_word);
      calm = (p == PHASES - 1);  // last phase runs with no idling at all
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // shift the insert share now and then so the table swings between empty and full
        if (n % 40 == 0) insert_pct = $urandom_range(30, 70);
        // receiver holds off long enough for the block to stall its input
        if (p == 1 && n == 50) hold_req = 1'b1;
        // sender pauses until every outstanding result beat is back
        if (p == 2 && n == 75) wait_drained();
        offer_item(random_item(), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain, then give the block time to show any stray beat
    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS ready_queue_dispatcher_top");
    end else begin
      $display("FAIL ready_queue_dispatcher_top");
    end
    $finish;
  end

endmodule
